// ----- sv/tsg_pkg.sv -----
// Shared types and constants for the timed sine tone generator.
// No dependencies; the files that use it refer to this package by scoped names.
`default_nettype none

package tsg_pkg;

    // default build parameters
    localparam int unsigned SAMPLE_RATE_DEF     = 44100;
    localparam int unsigned PHASE_BITS_DEF      = 32;
    localparam int unsigned SINE_TABLE_BITS_DEF = 10;

    localparam int unsigned FRAME_BITS = 22;
    localparam int unsigned MS_PER_S   = 1000;
    localparam int unsigned AMP_BITS   = 15;
    localparam int unsigned SAMPLE_BITS = 16;

    localparam logic [AMP_BITS-1:0] PEAK_RESET = 15'd9830;
    localparam logic [AMP_BITS-1:0] FULL_SCALE = 15'd32767;

    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } op_e;

    typedef enum logic [2:0] {
        PRESET_NONE    = 3'd0,
        PRESET_OK      = 3'd1,
        PRESET_ALERT   = 3'd2,
        PRESET_ERROR   = 3'd3,
        PRESET_UNKNOWN = 3'd4
    } preset_e;

    localparam logic [15:0] OK_HZ      = 16'd880;
    localparam logic [15:0] OK_MS      = 16'd120;
    localparam logic [15:0] ALERT_HZ   = 16'd1175;
    localparam logic [15:0] ALERT_MS   = 16'd250;
    localparam logic [15:0] ERROR_HZ   = 16'd220;
    localparam logic [15:0] ERROR_MS   = 16'd400;
    localparam logic [15:0] UNKNOWN_HZ = 16'd660;
    localparam logic [15:0] UNKNOWN_MS = 16'd150;

    // per-word control carried next to the table read
    typedef struct packed {
        logic play;
        logic neg;
    } tick_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/tsg_const_div.sv -----
// Pipelined floor(x * NUM / DEN) for constant NUM and DEN, registered in pq/pr, pq_d/qr, then result.
// Uses NUM = DEN*Q + R and an exact reciprocal for the remainder part; needs tsg_pkg only
// through its instantiating module.
`default_nettype none

module tsg_const_div #(
    parameter int unsigned XW       = 16,
    parameter logic [63:0] NUM      = 64'd4294967296,
    parameter logic [63:0] DEN      = 64'd44100,
    parameter int unsigned OW       = 32,
    parameter bit          SATURATE = 1'b0
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    input  wire logic [XW-1:0] x,
    output logic               out_valid,
    output logic [OW-1:0]      result
);

    localparam logic [63:0] Q  = NUM / DEN;
    localparam logic [63:0] R  = NUM % DEN;
    localparam int unsigned QW = (Q == 64'd0) ? 1 : $clog2(Q + 64'd1);
    localparam int unsigned L  = $clog2(DEN);
    // x * R < 2^N
    localparam int unsigned N  = XW + L;
    localparam int unsigned MW = N + 1;
    localparam logic [63:0] M  = ((64'd1 << (N + L)) + DEN - 64'd1) / DEN;
    localparam int unsigned PW = XW + QW;
    localparam int unsigned YW = N + MW;
    localparam int unsigned FW = PW + 1;
    localparam int unsigned EW = FW + OW;

    localparam logic [QW-1:0] QC = Q[QW-1:0];
    localparam logic [N-1:0]  RC = R[N-1:0];
    localparam logic [MW-1:0] MC = M[MW-1:0];

    logic [2:0]    valid_reg;
    logic [PW-1:0] pq_reg;
    logic [PW-1:0] pq_d_reg;
    logic [N-1:0]  pr_reg;
    logic [XW-1:0] qr_reg;
    logic [OW-1:0] result_reg;

    logic [PW-1:0] pq_next;
    logic [N-1:0]  pr_next;
    logic [YW-1:0] y_prod;
    logic [XW-1:0] qr_next;
    logic [EW-1:0] full_sum;
    logic          over;
    logic [OW-1:0] result_next;

    assign pq_next = PW'(x) * PW'(QC);
    assign pr_next = N'(x) * RC;
    assign y_prod  = YW'(pr_reg) * YW'(MC);
    assign qr_next = XW'(y_prod >> (N + L));

    assign full_sum    = EW'(pq_d_reg) + EW'(qr_reg);
    assign over        = SATURATE && ((full_sum >> OW) != '0);
    assign result_next = over ? {OW{1'b1}} : full_sum[OW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
        pq_reg     <= pq_next;
        pr_reg     <= pr_next;
        pq_d_reg   <= pq_reg;
        qr_reg     <= qr_next;
        result_reg <= result_next;
    end

    assign out_valid = valid_reg[2];
    assign result    = result_reg;

endmodule

`default_nettype wire

// ----- sv/tsg_sine_rom.sv -----
// Quarter-wave sine magnitude ROM with a registered read port.
// Contents are built at elaboration from a Taylor series in Q30; uses tsg_pkg.
`default_nettype none

module tsg_sine_rom #(
    parameter int unsigned TABLE_BITS = tsg_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               rd_en,
    input  wire logic [TABLE_BITS-2:0]              rd_addr,
    output logic      [tsg_pkg::AMP_BITS-1:0]       rd_data
);

    localparam int unsigned AW      = TABLE_BITS - 1;
    localparam int unsigned DEPTH   = 1 << AW;
    localparam logic [63:0] QUARTER = 64'd1 << (TABLE_BITS - 2);
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

    typedef logic [tsg_pkg::AMP_BITS-1:0] qtab_t [DEPTH];

    // round(32767 * sin(pi/2 * r / QUARTER))
    function automatic logic [tsg_pkg::AMP_BITS-1:0] quarter_sine(logic [63:0] r);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        x    = HALF_PI_Q30 * r / QUARTER;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int k = 0; k < 5; k++) begin
            term = (term * x2) >> 30;
            term = term / TAYLOR_DIV[k];
            if ((k % 2) == 0) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        v = ((unsigned'(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[tsg_pkg::AMP_BITS-1:0];
    endfunction

    function automatic qtab_t build_tab();
        qtab_t t;
        for (int j = 0; j < DEPTH; j++) begin
            if (64'(j) <= QUARTER) begin
                t[j] = quarter_sine(64'(j));
            end else begin
                t[j] = '0;
            end
        end
        return t;
    endfunction

    localparam qtab_t QTAB = build_tab();

    logic [tsg_pkg::AMP_BITS-1:0] data_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            data_reg <= QTAB[rd_addr];
        end
    end

    assign rd_data = data_reg;

endmodule

`default_nettype wire

// ----- sv/tsg_amp_scale.sv -----
// Scales a table magnitude by peak amplitude / full scale, then applies sign or mutes.
// Division by 2^15-1 is folded into an add and two compares; uses tsg_pkg.
`default_nettype none

module tsg_amp_scale (
    input  wire logic [tsg_pkg::AMP_BITS-1:0]     peak,
    input  wire logic [tsg_pkg::AMP_BITS-1:0]     mag,
    input  wire tsg_pkg::tick_ctrl_t              ctrl,
    output logic signed [tsg_pkg::SAMPLE_BITS-1:0] sample
);

    localparam int unsigned AB = tsg_pkg::AMP_BITS;
    localparam int unsigned PB = 2 * AB;
    localparam int unsigned SB = tsg_pkg::SAMPLE_BITS;
    localparam logic [AB:0] ONE_FS = {1'b0, tsg_pkg::FULL_SCALE};
    localparam logic [AB:0] TWO_FS = {tsg_pkg::FULL_SCALE, 1'b0};

    logic [PB-1:0] prod;
    logic [AB-1:0] hi;
    logic [AB-1:0] lo;
    logic [AB:0]   fold;
    logic [AB:0]   adj;
    logic [AB:0]   quo;

    // p = hi*2^15 + lo = hi*(2^15-1) + (hi + lo), and hi + lo < 2*(2^15-1) + 1
    assign prod = PB'(peak) * PB'(mag);
    assign hi   = prod[PB-1:AB];
    assign lo   = prod[AB-1:0];
    assign fold = (AB+1)'(hi) + (AB+1)'(lo);

    always_comb begin
        if (fold >= TWO_FS) begin
            adj = (AB+1)'(2);
        end else if (fold >= ONE_FS) begin
            adj = (AB+1)'(1);
        end else begin
            adj = '0;
        end
        quo = (AB+1)'(hi) + adj;
        if (!ctrl.play) begin
            sample = '0;
        end else if (ctrl.neg) begin
            sample = -signed'(SB'(quo));
        end else begin
            sample = signed'(SB'(quo));
        end
    end

endmodule

`default_nettype wire

// ----- sv/timed_sine_tone_generator.sv -----
// Timed sine tone generator: DDS beep source with a frame-counted duration.
//
// Input stream (s_*): one word per item. s_tuser is the operation: start a tone or
// produce one sample tick. A start word loads frequency and duration, either from its
// own fields or from a preset, clears the phase and gives no output word.
// Output stream (m_*): one word per tick: the signed sample and a playing flag.
// Silent ticks (no frames left) give sample 0 with playing low.
// Configuration: cfg_wr_en / cfg_wr_data write the peak amplitude; write only when idle.
//
// Ticks: one per cycle while s_tready is high; the sine ROM read and st1 register load at
// the accepting edge, then scaling into the output register raises m_tvalid. A start word runs
// through the three-stage step and frame-count divider pipelines, so s_tready is low until
// the step result has been loaded.
// Reset (aresetn low, synchronous) clears phase, step, frame count and all valid
// flags and restores the peak amplitude to its default. When the receiver stalls,
// the output word holds, the ROM stage holds one more tick, and s_tready drops.
//
// Depends on tsg_pkg, tsg_const_div, tsg_sine_rom, tsg_amp_scale.
`default_nettype none

module timed_sine_tone_generator #(
    parameter int unsigned SAMPLE_RATE     = tsg_pkg::SAMPLE_RATE_DEF,
    parameter int unsigned PHASE_BITS      = tsg_pkg::PHASE_BITS_DEF,
    parameter int unsigned SINE_TABLE_BITS = tsg_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [14:0] cfg_wr_data,  // peak_amplitude
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,      // tone_hz[15:0], duration_ms[31:16], preset[34:32]
    input  wire logic [0:0]  s_tuser,      // operation[0]
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,      // sample[15:0]
    output logic [0:0]       m_tuser       // playing[0]
);

    localparam int unsigned FB = tsg_pkg::FRAME_BITS;
    localparam int unsigned TB = SINE_TABLE_BITS;
    localparam int unsigned AW = TB - 1;
    localparam logic [AW-1:0] QUARTER_C = AW'(1) << (TB - 2);

    // input fields
    logic [15:0] in_hz;
    logic [15:0] in_ms;
    logic [2:0]  in_preset;
    logic        in_op;

    assign in_hz     = s_tdata[15:0];
    assign in_ms     = s_tdata[31:16];
    assign in_preset = s_tdata[34:32];
    assign in_op     = s_tuser[0];

    // state
    logic [PHASE_BITS-1:0]        phase_acc_reg;
    logic [PHASE_BITS-1:0]        phase_step_reg;
    logic [FB-1:0]                frames_left_reg;
    logic [tsg_pkg::AMP_BITS-1:0] peak_reg;
    logic                         setup_busy_reg;

    logic                         st1_valid_reg;
    tsg_pkg::tick_ctrl_t          st1_ctrl_reg;
    logic                         m_valid_reg;
    logic [15:0]                  m_sample_reg;
    logic                         m_playing_reg;

    logic in_acc;
    logic tick_acc;
    logic start_acc;
    logic st2_load;

    assign st2_load  = !m_valid_reg || m_tready;
    assign s_tready  = !setup_busy_reg && (!st1_valid_reg || st2_load);
    assign in_acc    = s_tvalid && s_tready;
    assign tick_acc  = in_acc && (in_op == tsg_pkg::OP_TICK);
    assign start_acc = in_acc && (in_op == tsg_pkg::OP_START);

    // preset resolution
    logic [15:0] sel_hz;
    logic [15:0] sel_ms;

    always_comb begin
        case (in_preset)
            tsg_pkg::PRESET_NONE: begin
                sel_hz = in_hz;
                sel_ms = in_ms;
            end
            tsg_pkg::PRESET_OK: begin
                sel_hz = tsg_pkg::OK_HZ;
                sel_ms = tsg_pkg::OK_MS;
            end
            tsg_pkg::PRESET_ALERT: begin
                sel_hz = tsg_pkg::ALERT_HZ;
                sel_ms = tsg_pkg::ALERT_MS;
            end
            tsg_pkg::PRESET_ERROR: begin
                sel_hz = tsg_pkg::ERROR_HZ;
                sel_ms = tsg_pkg::ERROR_MS;
            end
            default: begin
                sel_hz = tsg_pkg::UNKNOWN_HZ;
                sel_ms = tsg_pkg::UNKNOWN_MS;
            end
        endcase
    end

    // step = hz * 2^PHASE_BITS / rate, frames = ms * rate / 1000
    logic                  step_done;
    logic [PHASE_BITS-1:0] step_val;
    logic                  frames_done;
    logic [FB-1:0]         frames_val;

    tsg_const_div #(
        .XW       (16),
        .NUM      (64'd1 << PHASE_BITS),
        .DEN      (64'(SAMPLE_RATE)),
        .OW       (PHASE_BITS),
        .SATURATE (1'b0)
    ) u_step_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (start_acc),
        .x         (sel_hz),
        .out_valid (step_done),
        .result    (step_val)
    );

    tsg_const_div #(
        .XW       (16),
        .NUM      (64'(SAMPLE_RATE)),
        .DEN      (64'(tsg_pkg::MS_PER_S)),
        .OW       (FB),
        .SATURATE (1'b1)
    ) u_frames_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (start_acc),
        .x         (sel_ms),
        .out_valid (frames_done),
        .result    (frames_val)
    );

    // table address folding for quarter-wave symmetry
    logic [TB-1:0]       idx;
    logic [TB-3:0]       idx_r;
    logic [AW-1:0]       rom_addr;
    tsg_pkg::tick_ctrl_t tick_ctrl;

    assign idx            = phase_acc_reg[PHASE_BITS-1 -: TB];
    assign idx_r          = idx[TB-3:0];
    assign rom_addr       = idx[TB-2] ? (QUARTER_C - AW'(idx_r)) : AW'(idx_r);
    assign tick_ctrl.play = (frames_left_reg != '0);
    assign tick_ctrl.neg  = idx[TB-1];

    logic [tsg_pkg::AMP_BITS-1:0] rom_mag;

    tsg_sine_rom #(
        .TABLE_BITS (TB)
    ) u_rom (
        .aclk    (aclk),
        .rd_en   (tick_acc),
        .rd_addr (rom_addr),
        .rd_data (rom_mag)
    );

    logic signed [15:0] scaled;

    tsg_amp_scale u_scale (
        .peak   (peak_reg),
        .mag    (rom_mag),
        .ctrl   (st1_ctrl_reg),
        .sample (scaled)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_acc_reg   <= '0;
            phase_step_reg  <= '0;
            frames_left_reg <= '0;
            peak_reg        <= tsg_pkg::PEAK_RESET;
            setup_busy_reg  <= 1'b0;
            st1_valid_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                peak_reg <= cfg_wr_data;
            end

            if (start_acc) begin
                setup_busy_reg <= 1'b1;
            end else if (step_done) begin
                setup_busy_reg <= 1'b0;
            end

            if (step_done) begin
                phase_acc_reg  <= '0;
                phase_step_reg <= step_val;
            end else if (tick_acc && tick_ctrl.play) begin
                phase_acc_reg  <= phase_acc_reg + phase_step_reg;
            end

            if (frames_done) begin
                frames_left_reg <= frames_val;
            end else if (tick_acc && tick_ctrl.play) begin
                frames_left_reg <= frames_left_reg - FB'(1);
            end

            if (tick_acc) begin
                st1_valid_reg <= 1'b1;
            end else if (st2_load) begin
                st1_valid_reg <= 1'b0;
            end

            if (st2_load) begin
                m_valid_reg <= st1_valid_reg;
            end
        end

        if (tick_acc) begin
            st1_ctrl_reg <= tick_ctrl;
        end
        if (st2_load && st1_valid_reg) begin
            m_sample_reg  <= scaled;
            m_playing_reg <= st1_ctrl_reg.play;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_sample_reg;
    assign m_tuser[0] = m_playing_reg;

endmodule

`default_nettype wire
